@@ rtl/rgbc_pkg.sv @@
// Shared types, constants and kernel arithmetic for the RGB 3x3 convolution stream.
package rgbc_pkg;

    localparam int MAX_WIDTH_DEF = 2048;
    localparam int MAX_HEIGHT    = 4096;
    localparam int ROW_W         = 12;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 13;
    localparam int SUM_W         = 13;
    localparam int BLUR_SHIFT    = 4;

    localparam logic [CFG_IDX_W-1:0] REG_KERNEL = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 2'd2;

    localparam logic [1:0] KERNEL_EDGE     = 2'd0;
    localparam logic [1:0] KERNEL_BLUR     = 2'd1;
    localparam logic [1:0] KERNEL_IDENTITY = 2'd2;
    localparam logic [1:0] KERNEL_SHARPEN  = 2'd3;

    localparam logic [1:0]       KERNEL_RESET = KERNEL_IDENTITY;
    localparam logic [11:0]      WIDTH_RESET  = 12'd640;
    localparam logic [ROW_W-1:0] HM1_RESET    = 12'd479;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } pixel_t;

    // One window column: three vertically adjacent pixels.
    typedef struct packed {
        pixel_t top;
        pixel_t mid;
        pixel_t bot;
    } column_t;

    // Element 2 is the newest (rightmost) column.
    typedef column_t [2:0] window_t;

    // Results that one stage slot will deliver, and how to form them.
    typedef struct packed {
        logic [1:0] count;
        logic       left_dup;
        logic       last;
    } emit_t;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       eol;
        logic       eof;
    } result_t;

    typedef logic signed [SUM_W-1:0] sum_t;

    typedef struct packed {
        sum_t red;
        sum_t green;
        sum_t blue;
    } sums_t;

    // Weighted sum of a 3x3 block, p[row*3 + col], for the selected kernel.
    function automatic sum_t kernel_sum(input logic [1:0] ks, input logic [8:0][7:0] p);
        sum_t corners;
        sum_t edges;
        sum_t centre;
        sum_t res;
        corners = sum_t'(p[0]) + sum_t'(p[2]) + sum_t'(p[6]) + sum_t'(p[8]);
        edges   = sum_t'(p[1]) + sum_t'(p[3]) + sum_t'(p[5]) + sum_t'(p[7]);
        centre  = sum_t'(p[4]);
        case (ks)
            KERNEL_EDGE:    res = (centre <<< 3) - corners - edges;
            KERNEL_BLUR:    res = corners + (edges <<< 1) + (centre <<< 2);
            KERNEL_SHARPEN: res = (centre <<< 2) + centre - edges;
            default:        res = centre;
        endcase
        return res;
    endfunction

    // Negative sums go to zero before the blur scaling; large ones saturate.
    function automatic logic [7:0] sat_pixel(input logic [1:0] ks, input sum_t s);
        sum_t       v;
        logic [7:0] p;
        v = (ks == KERNEL_BLUR) ? (s >>> BLUR_SHIFT) : s;
        if (s < 0)
            p = 8'h00;
        else if (v > sum_t'(255))
            p = 8'hff;
        else
            p = v[7:0];
        return p;
    endfunction

endpackage

@@ rtl/rgbc_filter.sv @@
// Kernel sums and saturation for the two results a window position can produce.
module rgbc_filter
    import rgbc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [1:0] kernel,
    input  emit_t      ctl,
    input  window_t    window,
    output logic [1:0] push_count,
    output result_t    res_a,
    output result_t    res_b
);

    emit_t   ctl_reg;
    sums_t   sums_a_reg;
    sums_t   sums_b_reg;
    sums_t   sums_a_next;
    sums_t   sums_b_next;
    column_t left_col;

    function automatic sums_t block_sums(input logic [1:0] ks, input column_t l,
                                         input column_t c, input column_t r);
        logic [8:0][7:0] pr;
        logic [8:0][7:0] pg;
        logic [8:0][7:0] pb;
        sums_t           s;
        pr = {r.bot.red, c.bot.red, l.bot.red, r.mid.red, c.mid.red, l.mid.red,
              r.top.red, c.top.red, l.top.red};
        pg = {r.bot.green, c.bot.green, l.bot.green, r.mid.green, c.mid.green, l.mid.green,
              r.top.green, c.top.green, l.top.green};
        pb = {r.bot.blue, c.bot.blue, l.bot.blue, r.mid.blue, c.mid.blue, l.mid.blue,
              r.top.blue, c.top.blue, l.top.blue};
        s.red   = kernel_sum(ks, pr);
        s.green = kernel_sum(ks, pg);
        s.blue  = kernel_sum(ks, pb);
        return s;
    endfunction

    // The first column of a line replicates itself as its left neighbor.
    assign left_col = ctl.left_dup ? window[1] : window[0];

    always_comb
    begin
        sums_a_next = block_sums(kernel, left_col, window[1], window[2]);
        // Last column of a line: the right edge is replicated.
        sums_b_next = block_sums(kernel, window[1], window[2], window[2]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else
            ctl_reg <= ctl;
    end

    always_ff @(posedge clk)
    begin
        sums_a_reg <= sums_a_next;
        sums_b_reg <= sums_b_next;
    end

    always_comb
    begin
        res_a.red   = sat_pixel(kernel, sums_a_reg.red);
        res_a.green = sat_pixel(kernel, sums_a_reg.green);
        res_a.blue  = sat_pixel(kernel, sums_a_reg.blue);
        res_a.eol   = ctl_reg.last;
        res_a.eof   = ctl_reg.last;
        res_b.red   = sat_pixel(kernel, sums_b_reg.red);
        res_b.green = sat_pixel(kernel, sums_b_reg.green);
        res_b.blue  = sat_pixel(kernel, sums_b_reg.blue);
        res_b.eol   = 1'b1;
        res_b.eof   = 1'b0;
    end

    assign push_count = ctl_reg.count;

endmodule

@@ rtl/rgb_convolve_3x3_stream.sv @@
// Top level of the RGB 3x3 convolution stream: line stores, window, control and output queue.
//
// Pixels enter in raster order on the input channel (kind = 0); the filtered
// pixel of line y-1, column x-1 leaves when pixel (x, y) is transferred, and the
// last pixel of a line also releases the right-edge pixel of the line above.
// After the final line of a frame, drain items (kind = 1) release the last line,
// one pixel per drain item; pixels offered while draining are taken and dropped.
// Results leave on the output channel with end_of_line and end_of_frame flags.
// A released result passes the read stage, window, filter registers and output queue.
// Throughput: one input item per clock while the input is ready, set by the single
// read port of each line store and the read-modify-write of one column per item.
// Entering the drain phase holds the input not ready while column 0 is prefetched.
// Each line store is written back in the cycle after it is read; consecutive
// accesses always touch different columns, so no forwarding path is needed.
// The output queue holds eight results; the input is held off when the queue
// plus the results still in the pipeline could not take two more, so a stalled
// receiver backs up into the input without losing anything.
// Reset clears the counters and the window and restores the registers to
// identity kernel, 640 pixels by 480 lines; the line stores are not cleared.
// Writing line_width or frame_height restarts the frame.
module rgb_convolve_3x3_stream
    import rgbc_pkg::*;
#(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  kind,
    input  logic [7:0]            red_in,
    input  logic [7:0]            green_in,
    input  logic [7:0]            blue_in,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            red_out,
    output logic [7:0]            green_out,
    output logic [7:0]            blue_out,
    output logic                  end_of_line,
    output logic                  end_of_frame,
    input  logic                  cfg_write,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int AW         = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int WM1_RST    = ((int'(WIDTH_RESET) > MAX_WIDTH) ? MAX_WIDTH
                                : int'(WIDTH_RESET)) - 1;
    localparam int FIFO_DEPTH = 8;
    localparam int PW         = $clog2(FIFO_DEPTH);
    localparam int CW         = $clog2(FIFO_DEPTH + 1);

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_DRAIN = 2'd2;
    localparam logic [1:0] OP_PRIME = 2'd3;

    // Configuration
    logic [1:0]       kernel_reg;
    logic [AW-1:0]    wm1_reg;
    logic [ROW_W-1:0] hm1_reg;
    logic [AW-1:0]    wm1_cfg;
    logic [ROW_W-1:0] hm1_cfg;
    logic [31:0]      lw_req;
    logic [12:0]      fh_m1;
    logic             restart;

    // Frame position
    logic [AW-1:0]    x_reg;
    logic [ROW_W-1:0] y_reg;
    logic [AW-1:0]    d_reg;
    logic             draining_reg;
    logic             prime_reg;
    logic [AW-1:0]    x_cur;
    logic [ROW_W-1:0] y_cur;
    logic             x_last;
    logic             y_last;
    logic             d_last;
    logic             drain_ok;
    logic             pixel_ok;
    logic             accept;
    logic [AW-1:0]    rd_addr;

    // Line stores
    pixel_t           upper_mem [MAX_WIDTH];
    pixel_t           middle_mem [MAX_WIDTH];
    pixel_t           up_rd_reg;
    pixel_t           mid_rd_reg;

    // Read-modify-write stage
    logic [1:0]       s1_op_reg;
    logic [1:0]       s1_op_next;
    emit_t            s1_ctl_reg;
    emit_t            s1_ctl_next;
    pixel_t           s1_pix_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic             s1_top_mid_reg;
    column_t          new_col;
    window_t          win_reg;
    window_t          win_next;
    emit_t            s2_ctl_reg;

    // Filter and output queue
    logic [1:0]       push_count;
    result_t          res_a;
    result_t          res_b;
    result_t          fifo_mem [FIFO_DEPTH];
    result_t          head;
    logic [PW-1:0]    wr_ptr_reg;
    logic [PW-1:0]    rd_ptr_reg;
    logic [PW-1:0]    wr_ptr_b;
    logic [CW-1:0]    count_reg;
    logic [CW+1:0]    committed;
    logic             pop;

    // Register values are saturated to the supported range when written.
    assign lw_req = 32'(cfg_data[11:0]);
    assign fh_m1  = cfg_data - 13'd1;

    always_comb
    begin
        if (lw_req < 32'd2)
            wm1_cfg = AW'(1);
        else if (lw_req > 32'(MAX_WIDTH))
            wm1_cfg = AW'(MAX_WIDTH - 1);
        else
            wm1_cfg = AW'(lw_req - 32'd1);
        if (cfg_data < 13'd2)
            hm1_cfg = ROW_W'(1);
        else if (cfg_data > 13'(MAX_HEIGHT))
            hm1_cfg = ROW_W'(MAX_HEIGHT - 1);
        else
            hm1_cfg = fh_m1[ROW_W-1:0];
    end

    assign restart = cfg_write && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg <= KERNEL_RESET;
            wm1_reg    <= AW'(WM1_RST);
            hm1_reg    <= HM1_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_KERNEL: kernel_reg <= cfg_data[1:0];
                REG_WIDTH:  wm1_reg    <= wm1_cfg;
                REG_HEIGHT: hm1_reg    <= hm1_cfg;
                default:    ;
            endcase
        end
    end

    // Input side
    assign x_cur    = (x_reg > wm1_reg) ? '0 : x_reg;
    assign y_cur    = (y_reg > hm1_reg) ? '0 : y_reg;
    assign x_last   = (x_cur == wm1_reg);
    assign y_last   = (y_cur == hm1_reg);
    assign d_last   = (d_reg == wm1_reg);
    assign drain_ok = draining_reg && !(d_reg > wm1_reg);
    assign pixel_ok = !draining_reg;

    // Room for the results already committed plus the two a new item may add.
    assign committed = (CW+2)'(count_reg) + (CW+2)'(s1_ctl_reg.count)
                     + (CW+2)'(s2_ctl_reg.count) + (CW+2)'(push_count);
    assign in_ready  = !prime_reg && (committed <= (CW+2)'(FIFO_DEPTH - 2));
    assign accept    = in_valid && in_ready;

    always_comb
    begin
        if (prime_reg)
            rd_addr = '0;
        else if (kind)
            rd_addr = d_last ? d_reg : d_reg + AW'(1);
        else
            rd_addr = x_cur;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg        <= '0;
            y_reg        <= '0;
            d_reg        <= '0;
            draining_reg <= 1'b0;
            prime_reg    <= 1'b0;
        end
        else if (restart)
        begin
            x_reg        <= '0;
            y_reg        <= '0;
            d_reg        <= '0;
            draining_reg <= 1'b0;
            prime_reg    <= 1'b0;
        end
        else
        begin
            prime_reg <= 1'b0;
            if (accept && kind && drain_ok)
            begin
                if (d_last)
                begin
                    d_reg        <= '0;
                    draining_reg <= 1'b0;
                end
                else
                begin
                    d_reg <= d_reg + AW'(1);
                end
            end
            else if (accept && !kind && pixel_ok)
            begin
                if (x_last)
                begin
                    x_reg <= '0;
                    if (y_last)
                    begin
                        // Frame complete: prefetch column 0 for the drain phase.
                        y_reg        <= '0;
                        draining_reg <= 1'b1;
                        d_reg        <= '0;
                        prime_reg    <= 1'b1;
                    end
                    else
                    begin
                        y_reg <= y_cur + ROW_W'(1);
                    end
                end
                else
                begin
                    x_reg <= x_cur + AW'(1);
                    y_reg <= y_cur;
                end
            end
        end
    end

    always_comb
    begin
        s1_op_next  = OP_NONE;
        s1_ctl_next = '0;
        if (prime_reg)
        begin
            s1_op_next = OP_PRIME;
        end
        else if (accept && kind)
        begin
            if (drain_ok)
            begin
                s1_op_next        = OP_DRAIN;
                s1_ctl_next.count = 2'd1;
                s1_ctl_next.last  = d_last;
            end
        end
        else if (accept && pixel_ok)
        begin
            s1_op_next = OP_PIXEL;
            if (y_cur != '0 && x_cur != '0)
                s1_ctl_next.count = x_last ? 2'd2 : 2'd1;
            s1_ctl_next.left_dup = (x_cur == AW'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_op_reg  <= OP_NONE;
            s1_ctl_reg <= '0;
        end
        else
        begin
            s1_op_reg  <= s1_op_next;
            s1_ctl_reg <= s1_ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        s1_pix_reg     <= '{red: red_in, green: green_in, blue: blue_in};
        s1_addr_reg    <= rd_addr;
        s1_top_mid_reg <= (y_cur < ROW_W'(2));
    end

    // Line stores: read at transfer, written back in the following cycle.
    always_ff @(posedge clk)
    begin
        up_rd_reg  <= upper_mem[rd_addr];
        mid_rd_reg <= middle_mem[rd_addr];
        if (s1_op_reg == OP_PIXEL)
        begin
            upper_mem[s1_addr_reg]  <= mid_rd_reg;
            middle_mem[s1_addr_reg] <= s1_pix_reg;
        end
    end

    // Near the top of the frame the middle line stands in for the upper one;
    // in the drain phase the bottom line is replicated.
    always_comb
    begin
        new_col.top = (s1_op_reg == OP_PIXEL && s1_top_mid_reg) ? mid_rd_reg : up_rd_reg;
        new_col.mid = mid_rd_reg;
        new_col.bot = (s1_op_reg == OP_PIXEL) ? s1_pix_reg : mid_rd_reg;
    end

    always_comb
    begin
        win_next = win_reg;
        case (s1_op_reg) inside
            OP_PIXEL, OP_DRAIN:
            begin
                win_next[0] = win_reg[1];
                win_next[1] = win_reg[2];
                win_next[2] = new_col;
            end
            OP_PRIME:
            begin
                win_next[1] = new_col;
                win_next[2] = new_col;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg    <= '0;
            s2_ctl_reg <= '0;
        end
        else
        begin
            win_reg    <= win_next;
            s2_ctl_reg <= s1_ctl_reg;
        end
    end

    rgbc_filter u_filter (
        .clk        (clk),
        .rst_n      (rst_n),
        .kernel     (kernel_reg),
        .ctl        (s2_ctl_reg),
        .window     (win_reg),
        .push_count (push_count),
        .res_a      (res_a),
        .res_b      (res_b)
    );

    // Output queue
    assign wr_ptr_b = wr_ptr_reg + PW'(1);
    assign pop      = out_valid && out_ready;

    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0)
            fifo_mem[wr_ptr_reg] <= res_a;
        if (push_count == 2'd2)
            fifo_mem[wr_ptr_b] <= res_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_reg + PW'(push_count);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            count_reg <= count_reg + CW'(push_count) - CW'(pop);
        end
    end

    assign head         = fifo_mem[rd_ptr_reg];
    assign out_valid    = (count_reg != '0);
    assign red_out      = head.red;
    assign green_out    = head.green;
    assign blue_out     = head.blue;
    assign end_of_line  = head.eol;
    assign end_of_frame = head.eof;

endmodule

@@ rtl/rgbc_checker.sv @@
// Port-level checks for the RGB 3x3 convolution stream, bound to the top level.
module rgbc_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red_out,
    input logic [7:0] green_out,
    input logic [7:0] blue_out,
    input logic       end_of_line,
    input logic       end_of_frame
);

    // A result that is not taken stays offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output valid dropped before transfer");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(red_out) && $stable(green_out)
            && $stable(blue_out) && $stable(end_of_line) && $stable(end_of_frame))
        else $error("output payload changed while stalled");

    // The last pixel of a frame is also the last pixel of its line.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && end_of_frame |-> end_of_line)
        else $error("end of frame without end of line");

    // Nothing is offered right after reset.
    assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("output valid right after reset");

endmodule

bind rgb_convolve_3x3_stream rgbc_checker u_rgbc_checker (.*);

@@ bench/rgb_convolve_3x3_stream_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the RGB 3x3 convolution stream, predicting every filtered pixel.
import rgbc_pkg::*;

class rgb_filter_predictor;
    localparam int IDX_W = $clog2(MAX_WIDTH_DEF);

    pixel_t      upper_store  [MAX_WIDTH_DEF];
    pixel_t      middle_store [MAX_WIDTH_DEF];
    column_t     window [3];
    int          column;
    int          row;
    int          drain_pos;
    bit          draining;
    logic [1:0]  kernel;
    logic [11:0] width_reg;
    logic [12:0] height_reg;
    result_t     pending_pixels [$];
    int          errors;
    int          taken_items;

    function new();
        foreach (upper_store[i])
        begin
            upper_store[i]  = '0;
            middle_store[i] = '0;
        end
        foreach (window[i])
            window[i] = '0;
        kernel      = KERNEL_RESET;
        width_reg   = WIDTH_RESET;
        height_reg  = 13'(HM1_RESET) + 13'd1;
        errors      = 0;
        taken_items = 0;
        restart_frame();
    endfunction

    function void restart_frame();
        column    = 0;
        row       = 0;
        drain_pos = 0;
        draining  = 1'b0;
    endfunction

    function int line_len();
        int w;
        w = int'(width_reg);
        if (w < 2)
            w = 2;
        if (w > MAX_WIDTH_DEF)
            w = MAX_WIDTH_DEF;
        return w;
    endfunction

    function int frame_rows();
        int h;
        h = int'(height_reg);
        if (h < 2)
            h = 2;
        if (h > MAX_HEIGHT)
            h = MAX_HEIGHT;
        return h;
    endfunction

    function void write_config(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        case (index)
            REG_KERNEL:
                kernel = data[1:0];
            REG_WIDTH:
            begin
                width_reg = data[11:0];
                restart_frame();
            end
            REG_HEIGHT:
            begin
                height_reg = data;
                restart_frame();
            end
            default:
                ;
        endcase
    endfunction

    function int channel_of(pixel_t p, int ch);
        case (ch)
            0:       return int'(p.red);
            1:       return int'(p.green);
            default: return int'(p.blue);
        endcase
    endfunction

    function logic [7:0] filter_channel(column_t l, column_t c, column_t r, int ch);
        int corners;
        int edges;
        int centre;
        int acc;
        corners = channel_of(l.top, ch) + channel_of(r.top, ch)
                + channel_of(l.bot, ch) + channel_of(r.bot, ch);
        edges   = channel_of(c.top, ch) + channel_of(l.mid, ch)
                + channel_of(r.mid, ch) + channel_of(c.bot, ch);
        centre  = channel_of(c.mid, ch);
        case (kernel)
            KERNEL_EDGE:    acc = 8 * centre - corners - edges;
            KERNEL_BLUR:    acc = corners + 2 * edges + 4 * centre;
            KERNEL_SHARPEN: acc = 5 * centre - edges;
            default:        acc = centre;
        endcase
        // Negative sums clamp to zero before the blur is scaled down.
        if (acc < 0)
            return 8'h00;
        if (kernel == KERNEL_BLUR)
            acc = acc >>> 4;
        if (acc > 255)
            return 8'hff;
        return acc[7:0];
    endfunction

    function void expect_pixel(column_t l, column_t c, column_t r, bit eol, bit eof);
        result_t e;
        e.red   = filter_channel(l, c, r, 0);
        e.green = filter_channel(l, c, r, 1);
        e.blue  = filter_channel(l, c, r, 2);
        e.eol   = eol;
        e.eof   = eof;
        pending_pixels.push_back(e);
    endfunction

    function void take_input(logic k, pixel_t pix);
        int      w;
        int      h;
        int      x;
        int      y;
        int      lc;
        int      rc;
        column_t lcol;
        column_t ccol;
        column_t rcol;
        column_t left;
        pixel_t  above;
        pixel_t  mid;
        w = line_len();
        h = frame_rows();
        if (k)
        begin
            if (!draining || drain_pos >= w)
                return;
            lc = (drain_pos == 0) ? 0 : drain_pos - 1;
            rc = (drain_pos == w - 1) ? drain_pos : drain_pos + 1;
            // The last line has no line below it, so its own row is repeated.
            lcol.top = upper_store[IDX_W'(lc)];
            lcol.mid = middle_store[IDX_W'(lc)];
            lcol.bot = lcol.mid;
            ccol.top = upper_store[IDX_W'(drain_pos)];
            ccol.mid = middle_store[IDX_W'(drain_pos)];
            ccol.bot = ccol.mid;
            rcol.top = upper_store[IDX_W'(rc)];
            rcol.mid = middle_store[IDX_W'(rc)];
            rcol.bot = rcol.mid;
            expect_pixel(lcol, ccol, rcol, drain_pos == w - 1, drain_pos == w - 1);
            drain_pos++;
            if (drain_pos >= w)
            begin
                draining  = 1'b0;
                drain_pos = 0;
            end
            taken_items++;
            return;
        end
        if (draining)
            return;
        x = column;
        y = row;
        if (x >= w)
            x = 0;
        if (y >= h)
            y = 0;
        mid   = middle_store[IDX_W'(x)];
        above = (y < 2) ? mid : upper_store[IDX_W'(x)];
        window[0]     = window[1];
        window[1]     = window[2];
        window[2].top = above;
        window[2].mid = mid;
        window[2].bot = pix;
        upper_store[IDX_W'(x)]  = mid;
        middle_store[IDX_W'(x)] = pix;
        if (y >= 1 && x >= 1)
        begin
            left = (x == 1) ? window[1] : window[0];
            expect_pixel(left, window[1], window[2], 1'b0, 1'b0);
            if (x == w - 1)
                expect_pixel(window[1], window[2], window[2], 1'b1, 1'b0);
        end
        x++;
        if (x >= w)
        begin
            x = 0;
            y++;
            if (y >= h)
            begin
                y         = 0;
                draining  = 1'b1;
                drain_pos = 0;
            end
        end
        column = x;
        row    = y;
        taken_items++;
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] seen);
        if (seen !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, seen);
            errors++;
        end
    endfunction

    function void check_output(result_t got);
        result_t want;
        if (pending_pixels.size() == 0)
        begin
            $error("unexpected result: red %0d green %0d blue %0d eol %0d eof %0d",
                   got.red, got.green, got.blue, got.eol, got.eof);
            errors++;
            return;
        end
        want = pending_pixels.pop_front();
        compare_field("red_out", want.red, got.red);
        compare_field("green_out", want.green, got.green);
        compare_field("blue_out", want.blue, got.blue);
        compare_field("end_of_line", 8'(want.eol), 8'(got.eol));
        compare_field("end_of_frame", 8'(want.eof), 8'(got.eof));
    endfunction

    function int outstanding();
        return pending_pixels.size();
    endfunction
endclass

module rgb_convolve_3x3_stream_tb;

    localparam int RANDOM_ITEMS  = 520;
    localparam int HOLD_CYCLES   = 200;
    localparam int SETTLE_CYCLES = 10;
    localparam int IDLE_LIMIT    = 3000;
    localparam int TALL_CUT      = 100;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    logic                  kind;
    logic [7:0]            red_in;
    logic [7:0]            green_in;
    logic [7:0]            blue_in;
    logic                  out_valid;
    logic                  out_ready;
    logic [7:0]            red_out;
    logic [7:0]            green_out;
    logic [7:0]            blue_out;
    logic                  end_of_line;
    logic                  end_of_frame;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    rgb_filter_predictor filter_model;
    bit                  steady       = 1'b0;
    bit                  hold_request = 1'b0;
    int                  idle_cycles  = 0;
    result_t             seen_pixel;

    rgb_convolve_3x3_stream i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .kind         (kind),
        .red_in       (red_in),
        .green_in     (green_in),
        .blue_in      (blue_in),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .red_out      (red_out),
        .green_out    (green_out),
        .blue_out     (blue_out),
        .end_of_line  (end_of_line),
        .end_of_frame (end_of_frame),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #6 clk = ~clk;

    // Mostly short gaps, now and then a long one.
    function int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function logic [7:0] pick_channel(bit extremes);
        if (extremes || $urandom_range(0, 4) == 0)
            return ($urandom_range(0, 1) != 0) ? 8'hff : 8'h00;
        return 8'($urandom_range(0, 255));
    endfunction

    function pixel_t pick_pixel(bit extremes);
        pixel_t p;
        p.red   = pick_channel(extremes);
        p.green = pick_channel(extremes);
        p.blue  = pick_channel(extremes);
        return p;
    endfunction

    task send_item(logic k, pixel_t pix);
        int gap;
        gap = steady ? 0 : pick_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid <= 1'b1;
        kind     <= k;
        red_in   <= pix.red;
        green_in <= pix.green;
        blue_in  <= pix.blue;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (filter_model.outstanding() != 0)
            @(negedge clk);
    endtask

    // Row-zero pixels give no result but may still be in flight, so let them settle.
    task wait_quiet();
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    // One frame of pixels followed by the drain of its last line. A cut ends the frame
    // early; noise adds items that the block has to drop.
    task run_frame(int w, int h, bit extremes, bit noisy, int cut, int pause_at);
        for (int i = 0; i < w * h; i++)
        begin
            if (i == cut)
                return;
            if (i == pause_at)
                wait_drained();
            if (noisy && $urandom_range(0, 29) == 0)
                send_item(1'b1, pick_pixel(1'b0));
            send_item(1'b0, pick_pixel(extremes));
        end
        for (int d = 0; d < w; d++)
        begin
            if (noisy && $urandom_range(0, 29) == 0)
                send_item(1'b0, pick_pixel(1'b0));
            send_item(1'b1, pick_pixel(1'b0));
        end
        if (noisy && $urandom_range(0, 1) == 0)
            send_item(1'b1, pick_pixel(1'b0));
    endtask

    always @(posedge clk)
    begin
        if (in_valid && in_ready)
            filter_model.take_input(kind, {red_in, green_in, blue_in});
        if (out_valid && out_ready)
        begin
            seen_pixel.red   = red_out;
            seen_pixel.green = green_out;
            seen_pixel.blue  = blue_out;
            seen_pixel.eol   = end_of_line;
            seen_pixel.eof   = end_of_frame;
            filter_model.check_output(seen_pixel);
        end
        if (cfg_write)
            filter_model.write_config(cfg_index, cfg_data);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        int stall;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_request = 1'b0;
                out_ready <= 1'b1;
            end
            else if (steady)
                out_ready <= 1'b1;
            else
            begin
                stall = pick_gap();
                if (stall == 0)
                    out_ready <= 1'b1;
                else
                begin
                    out_ready <= 1'b0;
                    repeat (stall) @(negedge clk);
                    out_ready <= 1'b1;
                end
            end
        end
    end

    initial
    begin
        int                    base;
        int                    phase;
        int                    r;
        int                    w_raw;
        int                    h_raw;
        int                    w;
        int                    cur_h;
        int                    cut;
        int                    pause_at;
        bit                    noisy;
        logic [CFG_DATA_W-1:0] data;

        filter_model = new();
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        kind      = 1'b0;
        red_in    = 8'h00;
        green_in  = 8'h00;
        blue_in   = 8'h00;
        cfg_write = 1'b0;
        cfg_index = REG_KERNEL;
        cfg_data  = '0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        // Identity kernel from reset; sizes below the minimum saturate to a 2x2 frame.
        write_reg(REG_WIDTH, 13'd1);
        write_reg(REG_HEIGHT, 13'd0);
        send_item(1'b1, 24'hffffff);    // drain before any frame has ended: dropped
        send_item(1'b0, 24'hff00ff);
        send_item(1'b0, 24'h00ff00);
        send_item(1'b0, 24'h000000);
        send_item(1'b0, 24'hffffff);
        send_item(1'b0, 24'h123456);    // pixel while the last line drains: dropped
        send_item(1'b1, 24'h000000);
        send_item(1'b1, 24'hffffff);
        send_item(1'b1, 24'h00ff00);    // drain with nothing left: dropped
        wait_quiet();
        write_reg(REG_KERNEL, {11'h7ff, KERNEL_EDGE});
        write_reg(REG_WIDTH, 13'd2);
        run_frame(2, 2, 1'b1, 1'b0, -1, -1);
        wait_quiet();
        write_reg(REG_KERNEL, {11'h000, KERNEL_SHARPEN});
        run_frame(2, 2, 1'b1, 1'b0, -1, -1);
        wait_quiet();
        write_reg(REG_KERNEL, {11'h2aa, KERNEL_BLUR});
        run_frame(2, 2, 1'b1, 1'b0, -1, -1);

        cur_h = 2;
        phase = 0;
        base  = filter_model.taken_items;
        while (filter_model.taken_items - base < RANDOM_ITEMS)
        begin
            wait_quiet();
            data      = 13'($urandom);
            data[1:0] = 2'($urandom_range(0, 3));
            write_reg(REG_KERNEL, data);
            r = $urandom_range(0, 9);
            if (r < 6)
                w_raw = $urandom_range(2, 8);
            else if (r < 8)
                w_raw = $urandom_range(9, 24);
            else if (r == 8)
                w_raw = $urandom_range(25, 64);
            else
                w_raw = $urandom_range(0, 1);
            h_raw = -1;
            if ($urandom_range(0, 1) != 0)
                h_raw = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 5);
            // This frame is long enough for a long receiver hold to back up the input.
            if (phase == 1)
            begin
                w_raw = 24;
                h_raw = 4;
            end
            if (h_raw >= 0)
            begin
                write_reg(REG_HEIGHT, 13'(h_raw));
                cur_h = (h_raw < 2) ? 2 : h_raw;
            end
            write_reg(REG_WIDTH, 13'(w_raw));
            w        = (w_raw < 2) ? 2 : w_raw;
            steady   = (phase != 1) && ($urandom_range(0, 5) == 0);
            noisy    = (phase != 1) && ($urandom_range(0, 3) == 0);
            cut      = (phase > 3 && $urandom_range(0, 7) == 0) ?
                       $urandom_range(1, w * cur_h - 1) : -1;
            pause_at = (phase == 3) ? (w * cur_h) / 2 : -1;
            if (phase == 1)
                hold_request = 1'b1;
            run_frame(w, cur_h, $urandom_range(0, 3) == 0, noisy, cut, pause_at);
            phase++;
        end
        steady = 1'b0;

        // Start of the tallest frame, cut short, and a write to an index past the list.
        wait_quiet();
        write_reg(REG_SPARE, 13'($urandom));
        write_reg(REG_KERNEL, {11'h7ff, KERNEL_SHARPEN});
        write_reg(REG_WIDTH, 13'd2);
        write_reg(REG_HEIGHT, 13'h1fff);
        run_frame(2, MAX_HEIGHT, 1'b1, 1'b1, TALL_CUT, -1);

        wait_quiet();
        if (filter_model.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

@@ files.f @@
rtl/rgbc_pkg.sv
rtl/rgbc_filter.sv
rtl/rgb_convolve_3x3_stream.sv
rtl/rgbc_checker.sv
bench/rgb_convolve_3x3_stream_tb.sv
